// ----- hdl/sdf_pkg.sv -----
// shared item types and register indexes for the spring-damper force core
package sdf_pkg;

   localparam int FractionBits = 16;
   localparam int MinDistance  = 7;
   localparam int CfgW         = 31;
   localparam int IdxW         = 2;

   localparam logic [IdxW-1:0] CSR_ENABLE = 2'd0;
   localparam logic [IdxW-1:0] CSR_REST   = 2'd1;
   localparam logic [IdxW-1:0] CSR_STIFF  = 2'd2;
   localparam logic [IdxW-1:0] CSR_DAMP   = 2'd3;

   typedef struct packed {
      logic signed [31:0] a_pos_x;
      logic signed [31:0] a_pos_y;
      logic signed [31:0] b_pos_x;
      logic signed [31:0] b_pos_y;
      logic signed [31:0] a_vel_x;
      logic signed [31:0] a_vel_y;
      logic signed [31:0] b_vel_x;
      logic signed [31:0] b_vel_y;
      logic               a_static;
      logic               b_static;
   } req_type;

   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic               apply_a;
      logic               apply_b;
      logic               saturated;
   } rsp_type;

endpackage

// ----- hdl/spring_damper_force_core.sv -----
// spring-damper force core: pipelined distance, spring and damping force
// throughput: one item per cycle while busy is low; the 33-stage square root and the restoring divider
// stages compute one root bit and one quotient bit per stage
// reset: synchronous, clears all valid bits and loads the register defaults; busy is high
// while reset is high; the receiver cannot stall, each result shows for one cycle
module spring_damper_force_core #(
   parameter int FRACTION_BITS = sdf_pkg::FractionBits,
   parameter int MIN_DISTANCE  = sdf_pkg::MinDistance
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  sdf_pkg::req_type            req_data,
   input  logic                        csr_write,
   input  logic [sdf_pkg::IdxW-1:0]    csr_index,
   input  logic [sdf_pkg::CfgW-1:0]    csr_data,
   output logic                        rsp_strobe,
   output sdf_pkg::rsp_type            rsp_data
);
   import sdf_pkg::*;

   localparam int LW       = 33;
   localparam int SQW      = 66;
   localparam int SQ_STEPS = 33;
   localparam int RW       = 35;
   localparam int EW       = 35;
   localparam int EMW      = 34;
   localparam int PW       = 66;
   localparam int DMW      = 63 - FRACTION_BITS;
   localparam int DPW      = DMW + 1;
   localparam int NW       = 97 - FRACTION_BITS;
   localparam int QW       = 65 - FRACTION_BITS;
   localparam int FW       = QW + 3;
   localparam int LAT      = QW + 41;

   localparam logic signed [FW-1:0] MaxF = {{(FW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [FW-1:0] MinF = {{(FW-31){1'b1}}, 31'b0};

   typedef struct packed {
      logic signed [32:0]     dx;
      logic signed [32:0]     dy;
      logic signed [DPW-1:0]  dampx;
      logic signed [DPW-1:0]  dampy;
      logic                   a_st;
      logic                   b_st;
   } sqc_type;

   typedef struct packed {
      logic [LW-1:0]          len;
      logic                   ovx;
      logic                   ovy;
      logic                   sgx;
      logic                   sgy;
      logic                   close;
      logic signed [DPW-1:0]  dampx;
      logic signed [DPW-1:0]  dampy;
      logic                   a_st;
      logic                   b_st;
   } dvc_type;

   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      logic signed [32:0] m;
      m = v[32] ? -v : v;
      return m[31:0];
   endfunction

   function automatic logic [32:0] axis_force(input logic [QW-1:0] q, input logic ov,
                                               input logic sg,
                                               input logic signed [DPW-1:0] dmp);
      logic [QW:0]           smag;
      logic signed [FW-1:0]  spr;
      logic signed [FW-1:0]  tot;
      logic [32:0]           r;
      smag = ov ? {1'b1, {QW{1'b0}}} : {1'b0, q};
      spr = $signed({2'b00, smag});
      if (sg) begin
         spr = -spr;
      end
      tot = spr + FW'(dmp);
      if (tot > MaxF) begin
         r = {1'b1, 32'h7fff_ffff};
      end else if (tot < MinF) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, tot[31:0]};
      end
      return r;
   endfunction

   // configuration registers
   logic               enable_ff;
   logic [CfgW-1:0]    rest_ff, stiff_ff, damp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         rest_ff   <= '0;
         stiff_ff  <= CfgW'(65536);
         damp_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ENABLE: enable_ff <= csr_data[0];
            CSR_REST:   rest_ff   <= csr_data;
            CSR_STIFF:  stiff_ff  <= csr_data;
            CSR_DAMP:   damp_ff   <= csr_data;
            default:    enable_ff <= enable_ff;
         endcase
      end
   end

   assign busy = reset;

   logic accept;
   assign accept = start & ~busy;

   // stage 1: differences
   logic               v1_ff;
   logic signed [32:0] dx1_ff, dy1_ff, dvx1_ff, dvy1_ff;
   logic               ast1_ff, bst1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      dx1_ff  <= 33'(req_data.b_pos_x) - 33'(req_data.a_pos_x);
      dy1_ff  <= 33'(req_data.b_pos_y) - 33'(req_data.a_pos_y);
      dvx1_ff <= 33'(req_data.b_vel_x) - 33'(req_data.a_vel_x);
      dvy1_ff <= 33'(req_data.b_vel_y) - 33'(req_data.a_vel_y);
      ast1_ff <= req_data.a_static;
      bst1_ff <= req_data.b_static;
   end

   // stage 2: squares and damping products
   logic               v2_ff;
   logic signed [32:0] dx2_ff, dy2_ff;
   logic [63:0]        sqx2_ff, sqy2_ff;
   logic [62:0]        dmx2_ff, dmy2_ff;
   logic               dsx2_ff, dsy2_ff, ast2_ff, bst2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx2_ff  <= dx1_ff;
      dy2_ff  <= dy1_ff;
      sqx2_ff <= 64'(mag33(dx1_ff)) * 64'(mag33(dx1_ff));
      sqy2_ff <= 64'(mag33(dy1_ff)) * 64'(mag33(dy1_ff));
      dmx2_ff <= 63'(mag33(dvx1_ff)) * 63'(damp_ff);
      dmy2_ff <= 63'(mag33(dvy1_ff)) * 63'(damp_ff);
      dsx2_ff <= dvx1_ff[32];
      dsy2_ff <= dvy1_ff[32];
      ast2_ff <= ast1_ff;
      bst2_ff <= bst1_ff;
   end

   // square root pipeline, index 0 holds the radicand
   logic              sv_ff    [0:SQ_STEPS];
   logic [SQW-1:0]    srad_ff  [0:SQ_STEPS];
   logic [LW-1:0]     sroot_ff [0:SQ_STEPS];
   logic [RW-1:0]     srem_ff  [0:SQ_STEPS];
   sqc_type           scar_ff  [0:SQ_STEPS];

   logic [DMW-1:0]    dmx2_sh, dmy2_sh;
   assign dmx2_sh = dmx2_ff[62:FRACTION_BITS];
   assign dmy2_sh = dmy2_ff[62:FRACTION_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else begin
         sv_ff[0] <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      srad_ff[0]        <= {1'b0, 65'(sqx2_ff) + 65'(sqy2_ff)};
      sroot_ff[0]       <= '0;
      srem_ff[0]        <= '0;
      scar_ff[0].dx     <= dx2_ff;
      scar_ff[0].dy     <= dy2_ff;
      scar_ff[0].dampx  <= dsx2_ff ? -$signed({1'b0, dmx2_sh}) : $signed({1'b0, dmx2_sh});
      scar_ff[0].dampy  <= dsy2_ff ? -$signed({1'b0, dmy2_sh}) : $signed({1'b0, dmy2_sh});
      scar_ff[0].a_st   <= ast2_ff;
      scar_ff[0].b_st   <= bst2_ff;
   end

   genvar k;
   for (k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      logic [RW+1:0] rnew;
      logic [RW+1:0] trial;
      logic          take;

      assign rnew  = {srem_ff[k], srad_ff[k][SQW-1-2*k -: 2]};
      assign trial = (RW+2)'({sroot_ff[k], 2'b01});
      assign take  = rnew >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         srad_ff[k+1]  <= srad_ff[k];
         scar_ff[k+1]  <= scar_ff[k];
         sroot_ff[k+1] <= {sroot_ff[k][LW-2:0], take};
         srem_ff[k+1]  <= take ? RW'(rnew - trial) : RW'(rnew);
      end
   end

   // extension stage
   logic               ve_ff;
   logic [LW-1:0]      lene_ff;
   logic signed [EW-1:0] exte_ff;
   logic               closee_ff;
   sqc_type            care_ff;
   logic [LW-1:0]      len_sq;

   assign len_sq = sroot_ff[SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else begin
         ve_ff <= sv_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      lene_ff   <= len_sq;
      exte_ff   <= $signed({2'b00, len_sq}) - $signed({4'b0000, rest_ff});
      closee_ff <= len_sq < LW'(MIN_DISTANCE);
      care_ff   <= scar_ff[SQ_STEPS];
   end

   // offset times extension
   logic               vp_ff;
   logic [LW-1:0]      lenp_ff;
   logic [PW-1:0]      pxp_ff, pyp_ff;
   logic               sgxp_ff, sgyp_ff, closep_ff;
   sqc_type            carp_ff;
   logic signed [EW-1:0] ext_abs;

   assign ext_abs = exte_ff[EW-1] ? -exte_ff : exte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else begin
         vp_ff <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      lenp_ff   <= lene_ff;
      pxp_ff    <= PW'(mag33(care_ff.dx)) * PW'(ext_abs[EMW-1:0]);
      pyp_ff    <= PW'(mag33(care_ff.dy)) * PW'(ext_abs[EMW-1:0]);
      sgxp_ff   <= care_ff.dx[32] ^ exte_ff[EW-1];
      sgyp_ff   <= care_ff.dy[32] ^ exte_ff[EW-1];
      closep_ff <= closee_ff;
      carp_ff   <= care_ff;
   end

   // times stiffness, split in halves
   logic               vq_ff;
   logic [LW-1:0]      lenq_ff;
   logic [63:0]        qlx_ff, qhx_ff, qly_ff, qhy_ff;
   logic               sgxq_ff, sgyq_ff, closeq_ff;
   sqc_type            carq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff <= 1'b0;
      end else begin
         vq_ff <= vp_ff;
      end
   end

   always_ff @(posedge clock) begin
      lenq_ff   <= lenp_ff;
      qlx_ff    <= 64'(pxp_ff[32:0]) * 64'(stiff_ff);
      qhx_ff    <= 64'(pxp_ff[65:33]) * 64'(stiff_ff);
      qly_ff    <= 64'(pyp_ff[32:0]) * 64'(stiff_ff);
      qhy_ff    <= 64'(pyp_ff[65:33]) * 64'(stiff_ff);
      sgxq_ff   <= sgxp_ff;
      sgyq_ff   <= sgyp_ff;
      closeq_ff <= closep_ff;
      carq_ff   <= carp_ff;
   end

   // numerator, overflow check and divider
   logic [96:0]        numx, numy;
   logic [NW-1:0]      nnx, nny;

   assign numx = 97'(qlx_ff) + {qhx_ff, 33'b0};
   assign numy = 97'(qly_ff) + {qhy_ff, 33'b0};
   assign nnx  = numx[96:FRACTION_BITS];
   assign nny  = numy[96:FRACTION_BITS];

   logic              dv_ff   [0:QW];
   logic [LW-1:0]     drx_ff  [0:QW];
   logic [LW-1:0]     dry_ff  [0:QW];
   logic [QW-1:0]     dqx_ff  [0:QW];
   logic [QW-1:0]     dqy_ff  [0:QW];
   logic [QW-1:0]     dnx_ff  [0:QW];
   logic [QW-1:0]     dny_ff  [0:QW];
   dvc_type           dcar_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= vq_ff;
      end
   end

   always_ff @(posedge clock) begin
      drx_ff[0]        <= {1'b0, nnx[NW-1:QW]};
      dry_ff[0]        <= {1'b0, nny[NW-1:QW]};
      dqx_ff[0]        <= '0;
      dqy_ff[0]        <= '0;
      dnx_ff[0]        <= nnx[QW-1:0];
      dny_ff[0]        <= nny[QW-1:0];
      dcar_ff[0].len   <= lenq_ff;
      dcar_ff[0].ovx   <= {1'b0, nnx} >= {lenq_ff, {QW{1'b0}}};
      dcar_ff[0].ovy   <= {1'b0, nny} >= {lenq_ff, {QW{1'b0}}};
      dcar_ff[0].sgx   <= sgxq_ff;
      dcar_ff[0].sgy   <= sgyq_ff;
      dcar_ff[0].close <= closeq_ff;
      dcar_ff[0].dampx <= carq_ff.dampx;
      dcar_ff[0].dampy <= carq_ff.dampy;
      dcar_ff[0].a_st  <= carq_ff.a_st;
      dcar_ff[0].b_st  <= carq_ff.b_st;
   end

   genvar j;
   for (j = 0; j < QW; j++) begin : g_div
      logic [LW:0] rx, ry;
      logic        tx, ty;

      assign rx = {drx_ff[j], dnx_ff[j][QW-1-j]};
      assign ry = {dry_ff[j], dny_ff[j][QW-1-j]};
      assign tx = rx >= {1'b0, dcar_ff[j].len};
      assign ty = ry >= {1'b0, dcar_ff[j].len};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         dcar_ff[j+1] <= dcar_ff[j];
         dnx_ff[j+1]  <= dnx_ff[j];
         dny_ff[j+1]  <= dny_ff[j];
         dqx_ff[j+1]  <= {dqx_ff[j][QW-2:0], tx};
         dqy_ff[j+1]  <= {dqy_ff[j][QW-2:0], ty};
         drx_ff[j+1]  <= tx ? LW'(rx - {1'b0, dcar_ff[j].len}) : LW'(rx);
         dry_ff[j+1]  <= ty ? LW'(ry - {1'b0, dcar_ff[j].len}) : LW'(ry);
      end
   end

   // sum, clip and output register
   logic [32:0] fx, fy;
   logic        active;
   dvc_type     dlast;

   assign dlast  = dcar_ff[QW];
   assign fx     = axis_force(dqx_ff[QW], dlast.ovx, dlast.sgx, dlast.dampx);
   assign fy     = axis_force(dqy_ff[QW], dlast.ovy, dlast.sgy, dlast.dampy);
   assign active = enable_ff & ~dlast.close;

   logic    strobe_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (active) begin
         rsp_ff.force_x   <= fx[31:0];
         rsp_ff.force_y   <= fy[31:0];
         rsp_ff.apply_a   <= ~dlast.a_st;
         rsp_ff.apply_b   <= ~dlast.b_st;
         rsp_ff.saturated <= fx[32] | fy[32];
      end else begin
         rsp_ff <= '0;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_strobe)
      else $error("item result missing at expected latency");

   a_apply_needs_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.apply_a || rsp_data.apply_b) |-> enable_ff)
      else $error("force applied while disabled");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.saturated |->
         (rsp_data.force_x == 32'sh7fff_ffff || rsp_data.force_x == 32'sh8000_0000 ||
          rsp_data.force_y == 32'sh7fff_ffff || rsp_data.force_y == 32'sh8000_0000))
      else $error("saturation flag without clipped component");

endmodule

// ----- bench/spring_damper_force_core_test.sv -----
// self-checking bench for the spring-damper force core: directed and random items against a force predictor
`timescale 1ns / 100ps

module spring_damper_force_core_test;
   import sdf_pkg::*;

   localparam int Latency = 106 - FractionBits;
   localparam longint CycleLimit = 400000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic csr_write;
   logic [IdxW-1:0] csr_index;
   logic [CfgW-1:0] csr_data;
   logic rsp_strobe;
   rsp_type rsp_data;

   spring_damper_force_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   req_type pending_items[$];
   rsp_type expected_forces[$];
   int mismatches = 0;
   longint cycles = 0;
   int gap_left = 0;

   bit en_reg;
   logic [30:0] rest_reg, stiff_reg, damp_reg;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic void add_pending(req_type it);
      pending_items = {pending_items, it};
   endfunction

   function automatic void add_expected(rsp_type r);
      expected_forces = {expected_forces, r};
   endfunction

   function automatic logic [33:0] root_floor(logic [66:0] n);
      logic [33:0] r;
      logic [33:0] t;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         t = r | (34'd1 << b);
         if ({67'd0, t} * {67'd0, t} <= {67'd0, n}) r = t;
      end
      return r;
   endfunction

   function automatic logic signed [64:0] spring_term(logic signed [33:0] delta,
                                                      logic signed [35:0] ext,
                                                      logic [33:0] len);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      logic [33:0] md;
      logic [35:0] me;
      md = delta < 0 ? -delta : delta;
      me = ext < 0 ? -ext : ext;
      num = 128'(md) * 128'(me) * 128'(stiff_reg);
      den = 128'(len) << FractionBits;
      q = num / den;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      return ((delta < 0) != (ext < 0)) ? -$signed({1'b0, q[63:0]}) : $signed({1'b0, q[63:0]});
   endfunction

   function automatic logic signed [64:0] damp_term(logic signed [33:0] dv);
      logic [127:0] m;
      m = (128'(dv < 0 ? -dv : dv) * 128'(damp_reg)) >> FractionBits;
      return dv < 0 ? -$signed({1'b0, m[63:0]}) : $signed({1'b0, m[63:0]});
   endfunction

   function automatic rsp_type predict_force(req_type it);
      rsp_type r;
      logic signed [33:0] dx, dy, dvx, dvy;
      logic [33:0] len;
      logic signed [35:0] ext;
      logic signed [65:0] fx, fy;
      bit sat;
      r = '0;
      sat = 0;
      dx = 34'(it.b_pos_x) - 34'(it.a_pos_x);
      dy = 34'(it.b_pos_y) - 34'(it.a_pos_y);
      dvx = 34'(it.b_vel_x) - 34'(it.a_vel_x);
      dvy = 34'(it.b_vel_y) - 34'(it.a_vel_y);
      if (!en_reg) return r;
      len = root_floor(67'(dx) * 67'(dx) + 67'(dy) * 67'(dy));
      if (len < MinDistance) return r;
      ext = $signed({2'b0, len}) - $signed({5'b0, rest_reg});
      fx = 66'(spring_term(dx, ext, len)) + 66'(damp_term(dvx));
      fy = 66'(spring_term(dy, ext, len)) + 66'(damp_term(dvy));
      if (fx > 66'sd2147483647) begin fx = 66'sd2147483647; sat = 1; end
      if (fx < -66'sd2147483648) begin fx = -66'sd2147483648; sat = 1; end
      if (fy > 66'sd2147483647) begin fy = 66'sd2147483647; sat = 1; end
      if (fy < -66'sd2147483648) begin fy = -66'sd2147483648; sat = 1; end
      r.force_x = fx[31:0];
      r.force_y = fy[31:0];
      r.apply_a = !it.a_static;
      r.apply_b = !it.b_static;
      r.saturated = sat;
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
         2: return 32'(signed'($urandom_range(0, 40)) - 20);
         3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return 32'(signed'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
      endcase
   endfunction

   function automatic req_type rand_item();
      req_type it;
      it.a_pos_x = rand_coord();
      it.a_pos_y = rand_coord();
      it.b_pos_x = rand_coord();
      it.b_pos_y = rand_coord();
      if ($urandom_range(0, 9) == 0) begin
         it.b_pos_x = it.a_pos_x + $urandom_range(0, 8) - 4;
         it.b_pos_y = it.a_pos_y + $urandom_range(0, 8) - 4;
      end
      it.a_vel_x = rand_coord();
      it.a_vel_y = rand_coord();
      it.b_vel_x = rand_coord();
      it.b_vel_y = rand_coord();
      it.a_static = $urandom_range(0, 1);
      it.b_static = $urandom_range(0, 1);
      return it;
   endfunction

   function automatic req_type make_item(logic [31:0] ax, ay, bx, by, vx, vy, sa, sb);
      req_type it;
      it = '{ax, ay, bx, by, vx, vy, ~vx, ~vy, sa[0], sb[0]};
      return it;
   endfunction

   task automatic write_reg(logic [IdxW-1:0] idx, logic [CfgW-1:0] val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 0;
      case (idx)
         CSR_ENABLE: en_reg = val[0];
         CSR_REST:   rest_reg = val;
         CSR_STIFF:  stiff_reg = val;
         default:    damp_reg = val;
      endcase
   endtask

   task automatic drain();
      wait (pending_items.size() == 0 && expected_forces.size() == 0);
      repeat (Latency + 10) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         req_data <= '0;
      end else if (start && !busy) begin
         add_expected(predict_force(req_data));
         void'(pending_items.pop_front());
         gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
         if ($urandom_range(0, 3) == 0) gap_left = 0;
         if (gap_left == 0 && pending_items.size() > 0) begin
            req_data <= pending_items[0];
         end else begin
            start <= 0;
         end
      end else if (!start && pending_items.size() > 0) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
         end else begin
            start <= 1;
            req_data <= pending_items[0];
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_forces.size() == 0) begin
            $display("%0t unexpected result, expected none actual %h", $time, rsp_data);
            mismatches++;
         end else begin
            rsp_type e;
            e = expected_forces.pop_front();
            if (e.force_x !== rsp_data.force_x)
               $display("%0t force_x expected %h actual %h", $time, e.force_x, rsp_data.force_x);
            if (e.force_y !== rsp_data.force_y)
               $display("%0t force_y expected %h actual %h", $time, e.force_y, rsp_data.force_y);
            if (e.apply_a !== rsp_data.apply_a)
               $display("%0t apply_a expected %b actual %b", $time, e.apply_a, rsp_data.apply_a);
            if (e.apply_b !== rsp_data.apply_b)
               $display("%0t apply_b expected %b actual %b", $time, e.apply_b, rsp_data.apply_b);
            if (e.saturated !== rsp_data.saturated)
               $display("%0t saturated expected %b actual %b", $time, e.saturated,
                        rsp_data.saturated);
            if (e !== rsp_data) mismatches++;
         end
      end
   end

   initial begin
      reset = 1;
      csr_write = 0;
      csr_index = CSR_ENABLE;
      csr_data = '0;
      en_reg = 1;
      rest_reg = 0;
      stiff_reg = 65536;
      damp_reg = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, reset settings
      add_pending(make_item(0, 0, 32'h00030000, 32'h00040000, 0, 0, 0, 0));
      add_pending(make_item(0, 0, 3, 0, 0, 0, 0, 0));
      add_pending(make_item(0, 0, 7, 0, 0, 0, 1, 0));
      add_pending(make_item(5, 5, 5, 5, 0, 0, 0, 1));
      add_pending(make_item(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                            32'h7fffffff, 32'h80000000, 1, 1));
      add_pending(make_item(32'h7fffffff, 0, 32'h80000000, 0, 32'h80000000,
                            32'h7fffffff, 0, 0));
      drain();
      write_reg(CSR_REST, 31'h7fffffff);
      write_reg(CSR_STIFF, 31'h7fffffff);
      write_reg(CSR_DAMP, 31'h7fffffff);
      add_pending(make_item(0, 0, 32'h00010000, 0, 32'h00010000, 0, 0, 0));
      add_pending(make_item(32'h80000000, 0, 32'h7fffffff, 0, 32'h80000000,
                            32'h80000000, 0, 0));
      add_pending(make_item(0, 0, 100, 100, 1, 32'hffffffff, 1, 0));
      drain();
      write_reg(CSR_ENABLE, 0);
      add_pending(make_item(0, 0, 32'h00030000, 32'h00040000, 32'h1234, 0, 0, 0));
      add_pending(make_item(32'h80000000, 0, 32'h7fffffff, 0, 0, 0, 0, 0));
      drain();
      write_reg(CSR_ENABLE, 1);

      for (int phase = 0; phase < 6; phase++) begin
         write_reg(CSR_REST, (phase == 1) ? 31'h7fffffff : (phase == 2 ? 31'd0 :
                   31'($urandom_range(0, 32'h00ffffff))));
         write_reg(CSR_STIFF, (phase == 3) ? 31'h7fffffff : (phase == 4 ? 31'd0 :
                   31'($urandom_range(0, 32'h0003ffff))));
         write_reg(CSR_DAMP, (phase == 3) ? 31'h7fffffff : (phase == 2 ? 31'd0 :
                   31'($urandom_range(0, 32'h0003ffff))));
         write_reg(CSR_ENABLE, (phase == 5) ? 0 : 1);
         for (int i = 0; i < 250; i++) add_pending(rand_item());
         drain();
      end
      write_reg(CSR_ENABLE, 1);

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
